>>> rtl/rspd_pkg.sv
// Shared types, codes and helpers for the response deframer.
`default_nettype none

package rspd_pkg;

  // End packet is a fixed length: flag, body, two checksum bytes.
  localparam int unsigned END_PACKET_BYTES = 14;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_DATA_FLAG = 2'd0;
  localparam logic [1:0] REG_END_FLAG  = 2'd1;
  localparam logic [1:0] REG_CONTINUE  = 2'd2;
  localparam logic [1:0] REG_MAX_LEN   = 2'd3;

  localparam logic [7:0] DATA_FLAG_RST = 8'd1;
  localparam logic [7:0] END_FLAG_RST  = 8'd2;
  localparam logic [6:0] CONTINUE_RST  = 7'd16;
  localparam logic [7:0] MAX_LEN_RST   = 8'd128;

  // Event kinds.
  localparam logic [2:0] EV_DATA_BYTE = 3'd0;
  localparam logic [2:0] EV_DATA_DONE = 3'd1;
  localparam logic [2:0] EV_CONTINUE  = 3'd2;
  localparam logic [2:0] EV_END       = 3'd3;
  localparam logic [2:0] EV_SYNC_ERR  = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        payload;
    logic              good;
    logic signed [7:0] status;
    logic [15:0]       count;
    logic              len_err;
  } ev_t;

  // 16-bit one's-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/rsp_response_deframer.sv
// Receive deframer: classifies link bytes, unpacks data and end packets, checks sums.
//
// rx channel: one received link byte per request (rx_valid_i / rx_stall_o).
// ev channel: zero or one event per byte (ev_valid_o / ev_stall_i): data
//   bytes, data packet done, continue, end packet, sync error.
// Registers on an APB-style port at 0x0, 0x4, 0x8, 0xC: data flag, end
//   flag, continue code, max data length. Write only while idle.
// Output: an event is registered (output or skid register) when its byte is taken.
//   Throughput: one byte per cycle while rx_stall_o is low; the framing state, the
//   running checksum add and the event decode are all done in the accept cycle.
// Stall: the output register holds its event; one more event lands in a
//   skid register, after which rx_stall_o rises until the skid drains.
// Reset: registers return to defaults, framing goes idle, both event
//   registers empty.
`default_nettype none

module rsp_response_deframer
  import rspd_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                rx_valid_i,
  output logic               rx_stall_o,
  input  wire  [7:0]         rx_byte_i,
  output logic               ev_valid_o,
  input  wire                ev_stall_i,
  output logic [2:0]         event_kind_o,
  output logic [7:0]         payload_byte_o,
  output logic               checksum_good_o,
  output logic signed [7:0]  end_status_o,
  output logic [15:0]        bytes_handled_o,
  output logic               length_error_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [APB_AW-1:0]  paddr,
  input  wire  [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_SUM_LO  = 3'd3;
  localparam logic [2:0] PH_SUM_HI  = 3'd4;
  localparam logic [2:0] PH_END     = 3'd5;

  localparam logic [7:0] END_SUM_IDX  = 8'(END_PACKET_BYTES - 2);
  localparam logic [7:0] END_LAST_IDX = 8'(END_PACKET_BYTES - 1);
  localparam logic [7:0] STATUS_IDX   = 8'd3;
  localparam logic [7:0] COUNT_LO_IDX = 8'd8;
  localparam logic [7:0] COUNT_HI_IDX = 8'd9;

  // Config registers
  logic [7:0] data_flag_q, end_flag_q, max_len_q;
  logic [6:0] cont_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_flag_q <= DATA_FLAG_RST;
      end_flag_q  <= END_FLAG_RST;
      cont_q      <= CONTINUE_RST;
      max_len_q   <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DATA_FLAG: data_flag_q <= pwdata[7:0];
        REG_END_FLAG:  end_flag_q  <= pwdata[7:0];
        REG_CONTINUE:  cont_q      <= pwdata[6:0];
        REG_MAX_LEN:   max_len_q   <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DATA_FLAG: prdata = {24'd0, data_flag_q};
      REG_END_FLAG:  prdata = {24'd0, end_flag_q};
      REG_CONTINUE:  prdata = {25'd0, cont_q};
      REG_MAX_LEN:   prdata = {24'd0, max_len_q};
      default:       prdata = '0;
    endcase
  end

  // Framing state
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  lo_q, lo_d;
  logic        pend_q, pend_d;
  logic [7:0]  rsum_lo_q, rsum_lo_d;
  logic [7:0]  status_q, status_d;
  logic [15:0] count_q, count_d;

  logic        rx_acc;
  logic        res_vld;
  ev_t         res;
  logic        len_err;
  logic [15:0] pair_sum;
  logic [7:0]  idx_inc;
  logic        good;

  assign rx_acc   = rx_valid_i & ~rx_stall_o;
  assign len_err  = (len_q > max_len_q);
  assign pair_sum = ones_add(sum_q, {rx_byte_i, lo_q});
  assign idx_inc  = idx_q + 8'd1;
  assign good     = ({rx_byte_i, rsum_lo_q} == sum_q);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    len_d     = len_q;
    sum_d     = sum_q;
    lo_d      = lo_q;
    pend_d    = pend_q;
    rsum_lo_d = rsum_lo_q;
    status_d  = status_q;
    count_d   = count_q;
    res_vld   = 1'b0;
    res       = '0;

    unique case (phase_q)
      PH_LEN: begin
        if (pend_q) begin
          sum_d  = pair_sum;
          pend_d = 1'b0;
        end else begin
          lo_d   = rx_byte_i;
          pend_d = 1'b1;
        end
        len_d   = rx_byte_i;
        idx_d   = '0;
        phase_d = (rx_byte_i == 8'd0) ? PH_SUM_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        idx_d = idx_inc;
        if (pend_q) begin
          sum_d  = pair_sum;
          pend_d = 1'b0;
        end else if (idx_inc == len_q) begin
          // odd length: pad the last byte with a zero high byte
          lo_d   = rx_byte_i;
          sum_d  = ones_add(sum_q, {8'd0, rx_byte_i});
          pend_d = 1'b0;
        end else begin
          lo_d   = rx_byte_i;
          pend_d = 1'b1;
        end
        if (idx_inc == len_q) phase_d = PH_SUM_LO;
        res_vld     = 1'b1;
        res.kind    = EV_DATA_BYTE;
        res.payload = rx_byte_i;
        res.len_err = len_err;
      end
      PH_SUM_LO: begin
        rsum_lo_d = rx_byte_i;
        phase_d   = PH_SUM_HI;
      end
      PH_SUM_HI: begin
        phase_d     = PH_IDLE;
        res_vld     = 1'b1;
        res.kind    = EV_DATA_DONE;
        res.good    = good;
        res.len_err = len_err;
      end
      PH_END: begin
        if (idx_q < END_SUM_IDX) begin
          if (pend_q) begin
            sum_d  = pair_sum;
            pend_d = 1'b0;
          end else begin
            lo_d   = rx_byte_i;
            pend_d = 1'b1;
          end
        end
        if (idx_q == STATUS_IDX) begin
          status_d = rx_byte_i;
        end else if (idx_q == COUNT_LO_IDX) begin
          count_d[7:0] = rx_byte_i;
        end else if (idx_q == COUNT_HI_IDX) begin
          count_d[15:8] = rx_byte_i;
        end else if (idx_q == END_SUM_IDX) begin
          rsum_lo_d = rx_byte_i;
        end
        if (idx_q >= END_LAST_IDX) begin
          phase_d    = PH_IDLE;
          res_vld    = 1'b1;
          res.kind   = EV_END;
          res.good   = good;
          res.status = status_q;
          res.count  = count_q;
        end else begin
          idx_d = idx_inc;
        end
      end
      default: begin
        // idle and unused codes
        phase_d = PH_IDLE;
        priority if (rx_byte_i == end_flag_q) begin
          sum_d    = '0;
          lo_d     = rx_byte_i;
          pend_d   = 1'b1;
          status_d = '0;
          count_d  = '0;
          idx_d    = 8'd1;
          phase_d  = PH_END;
        end else if (rx_byte_i == data_flag_q) begin
          sum_d   = '0;
          lo_d    = rx_byte_i;
          pend_d  = 1'b1;
          idx_d   = '0;
          phase_d = PH_LEN;
        end else if (rx_byte_i[6:0] == cont_q) begin
          res_vld  = 1'b1;
          res.kind = EV_CONTINUE;
        end else begin
          res_vld  = 1'b1;
          res.kind = EV_SYNC_ERR;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      idx_q     <= '0;
      len_q     <= '0;
      sum_q     <= '0;
      lo_q      <= '0;
      pend_q    <= 1'b0;
      rsum_lo_q <= '0;
      status_q  <= '0;
      count_q   <= '0;
    end else if (rx_acc) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
      lo_q      <= lo_d;
      pend_q    <= pend_d;
      rsum_lo_q <= rsum_lo_d;
      status_q  <= status_d;
      count_q   <= count_d;
    end
  end

  // Output register plus skid
  ev_t  out_q, skid_q;
  logic out_vld_q, skid_vld_q;
  logic out_free;
  logic new_ev;

  assign out_free = ~out_vld_q | ~ev_stall_i;
  assign new_ev   = rx_acc & res_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q | new_ev;
      skid_vld_q <= 1'b0;
    end else if (new_ev) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) out_q <= skid_q;
      else if (new_ev) out_q <= res;
    end else if (new_ev) begin
      skid_q <= res;
    end
  end

  assign rx_stall_o      = skid_vld_q;
  assign ev_valid_o      = out_vld_q;
  assign event_kind_o    = out_q.kind;
  assign payload_byte_o  = out_q.payload;
  assign checksum_good_o = out_q.good;
  assign end_status_o    = out_q.status;
  assign bytes_handled_o = out_q.count;
  assign length_error_o  = out_q.len_err;

endmodule

`default_nettype wire

>>> rtl/rspd_checker.sv
// Port-level checks for the response deframer, bound to the top level.
`default_nettype none

module rspd_checker
  import rspd_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              ev_valid_o,
  input wire              ev_stall_i,
  input wire [2:0]        event_kind_o,
  input wire [7:0]        payload_byte_o,
  input wire              checksum_good_o,
  input wire signed [7:0] end_status_o,
  input wire [15:0]       bytes_handled_o,
  input wire              length_error_o
);

  // A stalled event stays up with its kind and payload.
  a_ev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && ev_stall_i |=> ev_valid_o && $stable(event_kind_o)
      && $stable(payload_byte_o) && $stable(bytes_handled_o))
    else $error("stalled event changed");

  // Status and count only travel with end packet events.
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && event_kind_o != EV_END |-> end_status_o == 8'sd0
      && bytes_handled_o == 16'd0)
    else $error("end fields set on non-end event");

  // Checksum result only on packet completion events.
  a_good_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && checksum_good_o |-> event_kind_o == EV_DATA_DONE
      || event_kind_o == EV_END)
    else $error("checksum flag on wrong event");

  // Length error and payload belong to data packet events.
  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && (length_error_o || payload_byte_o != 8'd0)
      |-> event_kind_o == EV_DATA_BYTE || event_kind_o == EV_DATA_DONE)
    else $error("data fields on non-data event");

endmodule

bind rsp_response_deframer rspd_checker u_rspd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .ev_valid_o      (ev_valid_o),
  .ev_stall_i      (ev_stall_i),
  .event_kind_o    (event_kind_o),
  .payload_byte_o  (payload_byte_o),
  .checksum_good_o (checksum_good_o),
  .end_status_o    (end_status_o),
  .bytes_handled_o (bytes_handled_o),
  .length_error_o  (length_error_o)
);

`default_nettype wire
